/* rtl/core/lqt_pkg.sv */
package lqt_pkg;

  // widths of the observation fields
  localparam int LinkIdxW = 3;
  localparam int LatInW   = 16;
  localparam int ThrInW   = 22;
  localparam int RelInW   = 8;

  // widths of the per-link state
  localparam int LatAvgW = 24;
  localparam int ThrAvgW = 24;
  localparam int RelAvgW = 17;
  localparam int CountW  = 13;

  localparam int ScoreW = 8;

  // number of reachable link indices, the most entries a state table can have
  localparam int MaxLinks        = 2 ** LinkIdxW;
  localparam int NumLinksDefault = 8;

  // pre-quotient width ahead of the final divide by 125
  localparam int PreQW = 15;

  localparam logic [LatAvgW-1:0] LatReset = 24'd12800;
  localparam logic [ThrAvgW-1:0] ThrReset = 24'd20480;
  localparam logic [RelAvgW-1:0] RelReset = 17'd58982;
  localparam logic [CountW-1:0]  CountMax = 13'd5000;

  typedef struct packed {
    logic [LinkIdxW-1:0] idx;
    logic [LatAvgW-1:0] lat;
    logic [ThrAvgW-1:0] thr;
    logic [RelAvgW-1:0] rel;
  } sample_t;

  typedef struct packed {
    logic               oor;
    logic [LatAvgW-1:0] lat;
    logic [ThrAvgW-1:0] thr;
    logic [RelAvgW-1:0] rel;
    logic [CountW-1:0]  cnt;
  } avg_t;

endpackage

/* rtl/core/lqt_sample.sv */
module lqt_sample (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [lqt_pkg::LinkIdxW-1:0]        link_index_i,
  input  logic [lqt_pkg::LatInW-1:0]          latency_ms_i,
  input  logic [lqt_pkg::ThrInW-1:0]          down_kbps_i,
  input  logic [lqt_pkg::ThrInW-1:0]          up_kbps_i,
  input  logic [lqt_pkg::RelInW-1:0]          reliability_byte_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output lqt_pkg::sample_t                    smp_o
);

  // (down + up) * 128 / 125 via reciprocal, exact for the whole input range
  localparam int          ThrShift = 37;
  localparam logic [30:0] ThrRecip = 31'd1099511628;
  localparam logic [29:0] ThrBias  = 30'd62;

  logic                               vld_q;
  logic [lqt_pkg::LinkIdxW-1:0]       idx_q;
  logic [lqt_pkg::LatInW-1:0]         lat_q;
  logic [lqt_pkg::ThrInW-1:0]         down_q;
  logic [lqt_pkg::ThrInW-1:0]         up_q;
  logic [lqt_pkg::RelInW-1:0]         rb_q;

  logic [lqt_pkg::ThrInW:0]           thr_sum;
  logic [29:0]                        thr_scaled;
  logic [60:0]                        thr_prod;

  assign ready_o = ~vld_q | ready_i;
  assign valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      idx_q  <= link_index_i;
      lat_q  <= latency_ms_i;
      down_q <= down_kbps_i;
      up_q   <= up_kbps_i;
      rb_q   <= reliability_byte_i;
    end
  end

  always_comb begin
    thr_sum    = {1'b0, down_q} + {1'b0, up_q};
    thr_scaled = {thr_sum, 7'd0} + ThrBias;
    thr_prod   = thr_scaled * ThrRecip;

    smp_o.idx = idx_q;
    smp_o.lat = {lat_q, 8'd0};
    smp_o.thr = thr_prod[ThrShift +: lqt_pkg::ThrAvgW];
    // byte * 65536 / 255 rounded is byte * 257 plus one for the upper half
    smp_o.rel = {1'b0, rb_q, rb_q} + lqt_pkg::RelAvgW'(rb_q[lqt_pkg::RelInW-1]);
  end

endmodule

/* rtl/core/lqt_update.sv */
module lqt_update #(
  parameter int NUM_LINKS = lqt_pkg::NumLinksDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  lqt_pkg::sample_t smp_i,
  output logic             valid_o,
  input  logic             ready_i,
  output lqt_pkg::avg_t    avg_o
);

  localparam int Depth = (NUM_LINKS < lqt_pkg::MaxLinks) ? NUM_LINKS : lqt_pkg::MaxLinks;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // divide by 10 via reciprocal, exact below 2^30
  localparam int          DivShift = 31;
  localparam logic [27:0] DivRecip = 28'd214748365;

  function automatic logic [24:0] blend(input logic [23:0] old_v, input logic [23:0] smp_v);
    logic [27:0] acc;
    logic [55:0] prod;
    acc  = 28'(old_v) * 28'd9 + 28'(smp_v) + 28'd5;
    prod = acc * DivRecip;
    return prod[DivShift +: 25];
  endfunction

  logic                              vld_q;
  lqt_pkg::sample_t                  s_q;

  logic [lqt_pkg::LatAvgW-1:0]       lat_avg_q [Depth];
  logic [lqt_pkg::ThrAvgW-1:0]       thr_avg_q [Depth];
  logic [lqt_pkg::RelAvgW-1:0]       rel_avg_q [Depth];
  logic [lqt_pkg::CountW-1:0]        cnt_q     [Depth];

  logic                              in_range;
  logic                              fire;
  logic [AddrW-1:0]                  addr;
  logic [lqt_pkg::LatAvgW-1:0]       lat_old;
  logic [lqt_pkg::ThrAvgW-1:0]       thr_old;
  logic [lqt_pkg::RelAvgW-1:0]       rel_old;
  logic [lqt_pkg::CountW-1:0]        cnt_old;
  logic [24:0]                       lat_bl;
  logic [24:0]                       thr_bl;
  logic [24:0]                       rel_bl;
  logic [lqt_pkg::LatAvgW-1:0]       lat_new;
  logic [lqt_pkg::ThrAvgW-1:0]       thr_new;
  logic [lqt_pkg::RelAvgW-1:0]       rel_new;
  logic [lqt_pkg::CountW-1:0]        cnt_new;

  assign ready_o = ~vld_q | ready_i;
  assign valid_o = vld_q;
  assign fire    = vld_q & ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s_q <= smp_i;
    end
  end

  always_comb begin
    in_range = (int'(s_q.idx) < NUM_LINKS);
    addr     = s_q.idx[AddrW-1:0];
    lat_old  = lat_avg_q[addr];
    thr_old  = thr_avg_q[addr];
    rel_old  = rel_avg_q[addr];
    cnt_old  = cnt_q[addr];

    lat_bl  = blend(lat_old, s_q.lat);
    thr_bl  = blend(thr_old, s_q.thr);
    rel_bl  = blend(24'(rel_old), 24'(s_q.rel));
    lat_new = lat_bl[lqt_pkg::LatAvgW-1:0];
    thr_new = thr_bl[lqt_pkg::ThrAvgW-1:0];
    rel_new = rel_bl[lqt_pkg::RelAvgW-1:0];
    cnt_new = (cnt_old < lqt_pkg::CountMax) ? cnt_old + 1'b1 : cnt_old;

    avg_o.oor = ~in_range;
    avg_o.lat = lat_new;
    avg_o.thr = thr_new;
    avg_o.rel = rel_new;
    avg_o.cnt = cnt_new;
  end

  // read-modify-write completes in this stage, so a repeated link sees the new value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        lat_avg_q[i] <= lqt_pkg::LatReset;
        thr_avg_q[i] <= lqt_pkg::ThrReset;
        rel_avg_q[i] <= lqt_pkg::RelReset;
        cnt_q[i]     <= '0;
      end
    end else if (fire && in_range) begin
      lat_avg_q[addr] <= lat_new;
      thr_avg_q[addr] <= thr_new;
      rel_avg_q[addr] <= rel_new;
      cnt_q[addr]     <= cnt_new;
    end
  end

  // an average never moves away from its sample and never past it
  a_lat_between : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_range |-> (lat_new >= lat_old && lat_new <= s_q.lat) ||
                         (lat_new <= lat_old && lat_new >= s_q.lat))
    else $error("latency average left the old/sample interval");

  a_thr_between : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_range |-> (thr_new >= thr_old && thr_new <= s_q.thr) ||
                         (thr_new <= thr_old && thr_new >= s_q.thr))
    else $error("throughput average left the old/sample interval");

  a_rel_between : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_range |-> (rel_new >= rel_old && rel_new <= s_q.rel) ||
                         (rel_new <= rel_old && rel_new >= s_q.rel))
    else $error("reliability average left the old/sample interval");

endmodule

/* rtl/core/lqt_score.sv */
module lqt_score (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  lqt_pkg::avg_t               avg_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [lqt_pkg::ScoreW-1:0]  outage_o,
  output logic [lqt_pkg::ScoreW-1:0]  perf_o,
  output logic [lqt_pkg::ScoreW-1:0]  conf_o
);

  localparam int NumW = 36;
  localparam logic signed [NumW-1:0] OutDen   = 36'sd32768000;
  localparam logic signed [NumW-1:0] PerfDen  = 36'sd65536000;
  localparam logic signed [NumW-1:0] PerfBias = 36'sd19660800;

  localparam logic [lqt_pkg::CountW-1:0] ConfLowMax  = 13'd100;
  localparam logic [lqt_pkg::CountW-1:0] ConfHighMin = 13'd800;
  localparam logic [lqt_pkg::ScoreW-1:0] ConfLow     = 8'd25;
  localparam logic [lqt_pkg::ScoreW-1:0] ConfHigh    = 8'd204;

  // divide by 125 via reciprocal, exact for the pre-quotient range
  localparam int          QShift = 22;
  localparam logic [15:0] QRecip = 16'd33555;

  function automatic logic [8:0] div125(input logic [lqt_pkg::PreQW-1:0] x);
    logic [30:0] prod;
    prod = x * QRecip;
    return prod[QShift +: 9];
  endfunction

  typedef struct packed {
    logic                       oor;
    logic [lqt_pkg::PreQW-1:0]  out_x;
    logic [lqt_pkg::PreQW-1:0]  perf_x;
    logic [lqt_pkg::PreQW-1:0]  conf_x;
    logic                       conf_low;
    logic                       conf_high;
  } prequot_t;

  logic                        vld3_q;
  lqt_pkg::avg_t               a_q;
  logic                        vld4_q;
  prequot_t                    n_q;
  logic                        vld5_q;
  logic [lqt_pkg::ScoreW-1:0]  outage_q;
  logic [lqt_pkg::ScoreW-1:0]  perf_q;
  logic [lqt_pkg::ScoreW-1:0]  conf_q;

  logic                        rdy3;
  logic                        rdy4;

  logic signed [NumW-1:0]      rel_s;
  logic signed [NumW-1:0]      lat_s;
  logic signed [NumW-1:0]      thr_s;
  logic signed [NumW-1:0]      out_num;
  logic signed [NumW-1:0]      perf_num;
  logic [24:0]                 out_clip;
  logic [25:0]                 perf_clip;
  logic [32:0]                 out_w;
  logic [33:0]                 perf_w;
  logic [17:0]                 conf_w;
  prequot_t                    n_d;

  logic [8:0]                  q_out;
  logic [8:0]                  q_perf;
  logic [8:0]                  q_conf;
  logic [lqt_pkg::ScoreW-1:0]  outage_d;
  logic [lqt_pkg::ScoreW-1:0]  perf_d;
  logic [lqt_pkg::ScoreW-1:0]  conf_d;

  assign rdy4    = ~vld5_q | ready_i;
  assign rdy3    = ~vld4_q | rdy4;
  assign ready_o = ~vld3_q | rdy3;
  assign valid_o = vld5_q;
  assign outage_o = outage_q;
  assign perf_o   = perf_q;
  assign conf_o   = conf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else begin
      if (ready_o) begin
        vld3_q <= valid_i;
      end
      if (rdy3) begin
        vld4_q <= vld3_q;
      end
      if (rdy4) begin
        vld5_q <= vld4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      a_q <= avg_i;
    end
    if (vld3_q && rdy3) begin
      n_q <= n_d;
    end
    if (vld4_q && rdy4) begin
      outage_q <= outage_d;
      perf_q   <= perf_d;
      conf_q   <= conf_d;
    end
  end

  // clamped numerators, times 255, then the power-of-two part of the denominators
  always_comb begin
    rel_s    = NumW'(a_q.rel);
    lat_s    = NumW'(a_q.lat);
    thr_s    = NumW'(a_q.thr);
    out_num  = OutDen - 36'sd500 * rel_s + 36'sd256 * lat_s - 36'sd32 * thr_s;
    perf_num = 36'sd500 * rel_s + PerfBias - 36'sd768 * lat_s + 36'sd128 * thr_s;

    if (out_num < 0) begin
      out_clip = '0;
    end else if (out_num > OutDen) begin
      out_clip = OutDen[24:0];
    end else begin
      out_clip = out_num[24:0];
    end

    if (perf_num <= 0) begin
      perf_clip = '0;
    end else if (perf_num >= PerfDen) begin
      perf_clip = PerfDen[25:0];
    end else begin
      perf_clip = perf_num[25:0];
    end

    out_w  = {out_clip, 8'd0} - {8'd0, out_clip};
    perf_w = {perf_clip, 8'd0} - {8'd0, perf_clip};
    // only used when the count lies below 800, so ten bits suffice
    conf_w = {a_q.cnt[9:0], 8'd0} - {8'd0, a_q.cnt[9:0]};

    n_d.oor       = a_q.oor;
    n_d.out_x     = out_w[32:18];
    n_d.perf_x    = perf_w[33:19];
    n_d.conf_x    = conf_w[17:3];
    n_d.conf_low  = (a_q.cnt <= ConfLowMax);
    n_d.conf_high = (a_q.cnt >= ConfHighMin);
  end

  always_comb begin
    q_out  = div125(n_q.out_x);
    q_perf = div125(n_q.perf_x);
    q_conf = div125(n_q.conf_x);
    if (n_q.oor) begin
      outage_d = '0;
      perf_d   = '0;
      conf_d   = '0;
    end else begin
      outage_d = q_out[7:0];
      perf_d   = q_perf[7:0];
      if (n_q.conf_low) begin
        conf_d = ConfLow;
      end else if (n_q.conf_high) begin
        conf_d = ConfHigh;
      end else begin
        conf_d = q_conf[7:0];
      end
    end
  end

  a_quot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld4_q |-> !q_out[8] && !q_perf[8] && (n_q.conf_low || n_q.conf_high || !q_conf[8]))
    else $error("score quotient above 255");

  a_conf_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld5_q |-> conf_q == '0 || (conf_q >= ConfLow && conf_q <= ConfHigh))
    else $error("confidence outside its band");

  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld4_q && rdy4 && n_q.oor |=> outage_q == '0 && perf_q == '0 && conf_q == '0)
    else $error("unknown link gave a non-zero score");

endmodule

/* rtl/core/link_quality_tracker.sv */
// Link quality tracker.
// Input channel in_valid_i/in_ready_o carries one observation per transfer:
// link index, latency, downlink and uplink throughput and a reliability byte.
// Output channel out_valid_o/out_ready_i carries one result per observation,
// in order: outage, performance and confidence scores, each 0..255.
// Each observation updates that link's latency, throughput and reliability
// averages (weight 1/10) and its saturating count; a link index at or beyond
// NUM_LINKS changes nothing and returns all-zero scores.
// Throughput: one observation per cycle unless the output stalls, also for
// a repeated link, as state read, blend and write-back sit in a single stage.
// An observation is registered at the input, ahead of the average update,
// after it, after the score numerators and after the final divide by 125.
// Every stage has its own valid bit, so a stalled receiver only blocks the
// input once all five stages hold data; bubbles are squeezed out.
// Reset clears all averages to 50 ms, 20 Mbps and 0.9, all counts to zero
// and empties the pipeline.
module link_quality_tracker #(
  parameter int NUM_LINKS = lqt_pkg::NumLinksDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lqt_pkg::LinkIdxW-1:0]  link_index_i,
  input  logic [lqt_pkg::LatInW-1:0]    latency_ms_i,
  input  logic [lqt_pkg::ThrInW-1:0]    down_kbps_i,
  input  logic [lqt_pkg::ThrInW-1:0]    up_kbps_i,
  input  logic [lqt_pkg::RelInW-1:0]    reliability_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lqt_pkg::ScoreW-1:0]    outage_score_o,
  output logic [lqt_pkg::ScoreW-1:0]    perf_score_o,
  output logic [lqt_pkg::ScoreW-1:0]    confidence_score_o
);

  logic             smp_valid;
  logic             smp_ready;
  lqt_pkg::sample_t smp;
  logic             avg_valid;
  logic             avg_ready;
  lqt_pkg::avg_t    avg;

  lqt_sample u_sample (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (in_valid_i),
    .ready_o            (in_ready_o),
    .link_index_i       (link_index_i),
    .latency_ms_i       (latency_ms_i),
    .down_kbps_i        (down_kbps_i),
    .up_kbps_i          (up_kbps_i),
    .reliability_byte_i (reliability_byte_i),
    .valid_o            (smp_valid),
    .ready_i            (smp_ready),
    .smp_o              (smp)
  );

  lqt_update #(
    .NUM_LINKS (NUM_LINKS)
  ) u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (smp_valid),
    .ready_o (smp_ready),
    .smp_i   (smp),
    .valid_o (avg_valid),
    .ready_i (avg_ready),
    .avg_o   (avg)
  );

  lqt_score u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (avg_valid),
    .ready_o  (avg_ready),
    .avg_i    (avg),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .outage_o (outage_score_o),
    .perf_o   (perf_score_o),
    .conf_o   (confidence_score_o)
  );

endmodule
